// File: design/wavrp_pkg.sv
// ---------------------------------------------------------------------------
// WAV RIFF header parser package
// Shared payload types, parse phases, chunk tags and handshake structs.
// ---------------------------------------------------------------------------
package wavrp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  text_field;
    logic [5:0]  text_index;
    logic [7:0]  text_byte;
    logic [7:0]  channels;
    logic [31:0] sample_rate;
    logic [7:0]  sample_bits;
    logic [31:0] duration_sec;
    logic [5:0]  title_length;
    logic [5:0]  artist_length;
    logic [5:0]  album_length;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_RIFF, PH_FSIZE, PH_WAVE, PH_HDR, PH_FMT, PH_SKIP,
    PH_LTYPE, PH_SUBHDR, PH_TEXT, PH_SUBSKIP, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    CS_IDLE, CS_MUL1, CS_MUL2, CS_DIV, CS_OUT0, CS_OUT1
  } ctrl_state_e;

  localparam logic [1:0] KIND_TEXT    = 2'd0;
  localparam logic [1:0] KIND_VALID   = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  localparam logic [1:0] FIELD_TITLE  = 2'd0;
  localparam logic [1:0] FIELD_ARTIST = 2'd1;
  localparam logic [1:0] FIELD_ALBUM  = 2'd2;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [31:0] TAG_LIST = 32'h4C495354;
  localparam logic [31:0] TAG_INFO = 32'h494E464F;
  localparam logic [31:0] TAG_INAM = 32'h494E414D;
  localparam logic [31:0] TAG_IART = 32'h49415254;
  localparam logic [31:0] TAG_IPRD = 32'h49505244;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  typedef struct packed {
    logic step;
    logic mul1;
    logic mul2;
    logic div_step;
    logic out_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] step_n;
    logic       step_div;
    logic [1:0] n_q;
    logic       div_last;
  } sts_t;

endpackage

// File: design/wavrp_ctrl.sv
// ---------------------------------------------------------------------------
// WAV RIFF header parser controller
// Sequences byte intake, the duration multiply/divide and result delivery.
// ---------------------------------------------------------------------------
module wavrp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wavrp_pkg::cmd_t   cmd_o,
  input  wavrp_pkg::sts_t   sts_i
);

  wavrp_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wavrp_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      wavrp_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          if (sts_i.step_div) begin
            state_d = wavrp_pkg::CS_MUL1;
          end else if (sts_i.step_n != 2'd0) begin
            state_d = wavrp_pkg::CS_OUT0;
          end
        end
      end
      wavrp_pkg::CS_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = wavrp_pkg::CS_MUL2;
      end
      wavrp_pkg::CS_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = wavrp_pkg::CS_DIV;
      end
      wavrp_pkg::CS_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = wavrp_pkg::CS_OUT0;
        end
      end
      wavrp_pkg::CS_OUT0: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = (sts_i.n_q == 2'd2) ? wavrp_pkg::CS_OUT1 : wavrp_pkg::CS_IDLE;
        end
      end
      wavrp_pkg::CS_OUT1: begin
        out_valid_o   = 1'b1;
        cmd_o.out_sel = 1'b1;
        if (out_ready_i) begin
          state_d = wavrp_pkg::CS_IDLE;
        end
      end
      default: state_d = wavrp_pkg::CS_IDLE;
    endcase
  end

endmodule

// File: design/wavrp_dp.sv
// ---------------------------------------------------------------------------
// WAV RIFF header parser datapath
// Chunk parser registers, result slots, byte-rate multiply and serial divider.
// ---------------------------------------------------------------------------
module wavrp_dp #(
  parameter int TEXT_CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wavrp_pkg::in_item_t  in_data_i,
  input  wavrp_pkg::cmd_t      cmd_i,
  output wavrp_pkg::sts_t      sts_o,
  output wavrp_pkg::out_item_t out_data_o
);

  localparam int PW = (TEXT_CAPACITY > 2) ? $clog2(TEXT_CAPACITY) : 1;
  localparam logic [31:0] READ_MAX = 32'(TEXT_CAPACITY - 1);

  wavrp_pkg::phase_e phase_q, phase_d;
  logic [2:0]  fbc_q, fbc_d;
  // The fmt body is counted apart from the chunk-header counter: 16 bytes.
  logic [3:0]  fcnt_q, fcnt_d;
  logic [31:0] tag_q, tag_d, len_q, len_d, lrem_q, lrem_d, sub_q, sub_d;
  logic [32:0] skip_q, skip_d;
  logic [7:0]  ch_q, ch_d, bits_q, bits_d;
  logic [31:0] rate_q, rate_d, dur_q;
  logic        seen_fmt_q, seen_fmt_d, sent_q, sent_d;
  logic [1:0]  tgt_q, tgt_d;
  logic [PW-1:0] pos_q, pos_d;
  logic        zero_q, zero_d, lpad_q, lpad_d;
  logic [PW-1:0] len0_q, len0_d, len1_q, len1_d, len2_q, len2_d;
  wavrp_pkg::out_item_t res0_q, res0_d, res1_q, res1_d;
  logic [1:0]  n_q, n_d;
  logic        need_div;

  logic [31:0] dvd_q, dvs_q, quo_q;
  logic [32:0] rem_q;
  logic [39:0] prod1_q;
  logic [4:0]  cnt_q;
  logic [32:0] rem_shift;
  logic [31:0] quo_next;
  logic [36:0] prod2;

  function automatic wavrp_pkg::out_item_t mk_summary(
    input logic [1:0] kind, input logic [7:0] ch, input logic [31:0] rate,
    input logic [7:0] bits, input logic [31:0] dur,
    input logic [PW-1:0] l0, input logic [PW-1:0] l1, input logic [PW-1:0] l2);
    wavrp_pkg::out_item_t r;
    r               = '0;
    r.result_kind   = kind;
    r.channels      = ch;
    r.sample_rate   = rate;
    r.sample_bits   = bits;
    r.duration_sec  = dur;
    r.title_length  = 6'(l0);
    r.artist_length = 6'(l1);
    r.album_length  = 6'(l2);
    return r;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [2:0]  fbc_inc;
    logic [31:0] size, rd_len;
    logic [32:0] cnt_val;
    logic        do_top, do_sub, do_list;
    logic        pad;
    wavrp_pkg::out_item_t r;

    b = in_data_i.data_byte;
    if (in_data_i.file_start) begin
      phase_d = wavrp_pkg::PH_RIFF; fbc_d = '0; tag_d = '0; len_d = '0;
      lrem_d = '0; sub_d = '0; skip_d = '0; ch_d = '0; rate_d = '0;
      bits_d = '0; seen_fmt_d = 1'b0; sent_d = 1'b0; tgt_d = '0; pos_d = '0;
      zero_d = 1'b0; lpad_d = 1'b0; len0_d = '0; len1_d = '0; len2_d = '0;
      fcnt_d = '0;
    end else begin
      phase_d = phase_q; fbc_d = fbc_q; tag_d = tag_q; len_d = len_q;
      lrem_d = lrem_q; sub_d = sub_q; skip_d = skip_q; ch_d = ch_q;
      rate_d = rate_q; bits_d = bits_q; seen_fmt_d = seen_fmt_q;
      sent_d = sent_q; tgt_d = tgt_q; pos_d = pos_q; zero_d = zero_q;
      lpad_d = lpad_q; len0_d = len0_q; len1_d = len1_q; len2_d = len2_q;
      fcnt_d = fcnt_q;
    end
    res0_d   = '0;
    res1_d   = '0;
    n_d      = '0;
    need_div = 1'b0;
    do_top   = 1'b0;
    do_sub   = 1'b0;
    do_list  = 1'b0;
    cnt_val  = '0;
    size     = len_d;
    rd_len   = '0;
    pad      = 1'b0;
    fbc_inc  = fbc_d + 3'd1;
    r        = '0;

    unique case (phase_d)
      wavrp_pkg::PH_RIFF, wavrp_pkg::PH_WAVE: begin
        tag_d = {tag_d[23:0], b};
        fbc_d = fbc_inc;
        if (fbc_inc == 3'd4) begin
          fbc_d = '0;
          if (tag_d != ((phase_d == wavrp_pkg::PH_RIFF) ? wavrp_pkg::TAG_RIFF
                                                          : wavrp_pkg::TAG_WAVE)) begin
            res0_d  = mk_summary(wavrp_pkg::KIND_INVALID, ch_d, rate_d, bits_d, dur_q,
                                 len0_d, len1_d, len2_d);
            n_d     = 2'd1;
            sent_d  = 1'b1;
            phase_d = wavrp_pkg::PH_DONE;
          end else begin
            phase_d = (phase_d == wavrp_pkg::PH_RIFF) ? wavrp_pkg::PH_FSIZE
                                                      : wavrp_pkg::PH_HDR;
          end
        end
      end
      wavrp_pkg::PH_FSIZE: begin
        fbc_d = fbc_inc;
        if (fbc_inc == 3'd4) begin
          fbc_d   = '0;
          phase_d = wavrp_pkg::PH_WAVE;
        end
      end
      wavrp_pkg::PH_HDR, wavrp_pkg::PH_SUBHDR: begin
        if (!fbc_d[2]) tag_d = {tag_d[23:0], b};
        else len_d = {b, len_d[31:8]};
        fbc_d = fbc_inc;
        if (fbc_d == 3'd0) begin
          size = len_d;
          if (phase_d == wavrp_pkg::PH_HDR) begin
            if (tag_d == wavrp_pkg::TAG_FMT) begin
              sub_d   = size;
              fcnt_d  = '0;
              phase_d = wavrp_pkg::PH_FMT;
            end else if (tag_d == wavrp_pkg::TAG_DATA) begin
              need_div = 1'b1;
              res0_d   = mk_summary(seen_fmt_d ? wavrp_pkg::KIND_VALID
                                               : wavrp_pkg::KIND_INVALID,
                                    ch_d, rate_d, bits_d, dur_q, len0_d, len1_d, len2_d);
              n_d      = 2'd1;
              sent_d   = 1'b1;
              phase_d  = wavrp_pkg::PH_DONE;
            end else if (tag_d == wavrp_pkg::TAG_LIST) begin
              lrem_d  = size;
              phase_d = wavrp_pkg::PH_LTYPE;
            end else begin
              do_top  = 1'b1;
              cnt_val = {1'b0, size} + {32'd0, size[0]};
            end
          end else begin
            lrem_d = (lrem_d > 32'd8) ? lrem_d - 32'd8 : '0;
            size   = (len_d < lrem_d) ? len_d : lrem_d;
            lrem_d = lrem_d - size;
            pad    = size[0];
            lrem_d = (lrem_d > {31'd0, pad}) ? lrem_d - {31'd0, pad} : '0;
            if (tag_d == wavrp_pkg::TAG_INAM || tag_d == wavrp_pkg::TAG_IART ||
                tag_d == wavrp_pkg::TAG_IPRD) begin
              tgt_d = (tag_d == wavrp_pkg::TAG_INAM) ? wavrp_pkg::FIELD_TITLE :
                      (tag_d == wavrp_pkg::TAG_IART) ? wavrp_pkg::FIELD_ARTIST :
                                                       wavrp_pkg::FIELD_ALBUM;
              pos_d  = '0;
              zero_d = 1'b0;
              case (tgt_d)
                wavrp_pkg::FIELD_TITLE:  len0_d = '0;
                wavrp_pkg::FIELD_ARTIST: len1_d = '0;
                default:                 len2_d = '0;
              endcase
              rd_len = (READ_MAX < size) ? READ_MAX : size;
              sub_d  = rd_len;
              skip_d = {1'b0, size - rd_len} + {32'd0, pad};
              if (rd_len != '0) begin
                phase_d = wavrp_pkg::PH_TEXT;
              end else begin
                do_sub  = 1'b1;
                cnt_val = skip_d;
              end
            end else begin
              do_sub  = 1'b1;
              cnt_val = {1'b0, size} + {32'd0, pad};
            end
          end
        end
      end
      default: ;
    endcase

    unique case (phase_d)
      wavrp_pkg::PH_SKIP: begin
        skip_d = skip_d - 33'd1;
        if (skip_d == '0) phase_d = wavrp_pkg::PH_HDR;
      end
      wavrp_pkg::PH_FMT: begin
        if (phase_q == wavrp_pkg::PH_FMT && !in_data_i.file_start) begin
          if (fcnt_q == 4'd2) ch_d = b;
          if (fcnt_q[3:2] == 2'b01) len_d = {b, len_d[31:8]};
          if (fcnt_q == 4'd7) rate_d = len_d;
          if (fcnt_q == 4'd14) bits_d = b;
          fcnt_d = fcnt_q + 4'd1;
          if (fcnt_q == 4'd15) begin
            seen_fmt_d = 1'b1;
            do_top     = 1'b1;
            cnt_val    = {1'b0, (sub_d > wavrp_pkg::FMT_BODY_LEN) ?
                                sub_d - wavrp_pkg::FMT_BODY_LEN : 32'd0} +
                         {32'd0, sub_d[0]};
          end
        end
      end
      wavrp_pkg::PH_LTYPE: begin
        if (phase_q == wavrp_pkg::PH_LTYPE && !in_data_i.file_start) begin
          tag_d = {tag_d[23:0], b};
          fbc_d = fbc_inc;
          if (fbc_inc == 3'd4) begin
            fbc_d = '0;
            size  = lrem_d;
            if (tag_d == wavrp_pkg::TAG_INFO) begin
              lpad_d  = size[0];
              lrem_d  = (size > 32'd4) ? size - 32'd4 : '0;
              do_list = 1'b1;
            end else begin
              do_top  = 1'b1;
              cnt_val = {1'b0, (size > 32'd4) ? size - 32'd4 : 32'd0} + {32'd0, size[0]};
            end
          end
        end
      end
      wavrp_pkg::PH_TEXT: begin
        if (phase_q == wavrp_pkg::PH_TEXT && !in_data_i.file_start) begin
          r            = '0;
          r.text_field = tgt_d;
          r.text_index = 6'(pos_d);
          r.text_byte  = b;
          res0_d       = r;
          n_d          = 2'd1;
          if (!zero_d) begin
            if (b == 8'd0) begin
              zero_d = 1'b1;
            end else if (b != 8'h20) begin
              case (tgt_d)
                wavrp_pkg::FIELD_TITLE:  len0_d = pos_d + 1'b1;
                wavrp_pkg::FIELD_ARTIST: len1_d = pos_d + 1'b1;
                default:                 len2_d = pos_d + 1'b1;
              endcase
            end
          end
          pos_d = pos_d + 1'b1;
          if ({{(32-PW){1'b0}}, pos_d} >= sub_d || pos_d == '0) begin
            do_sub  = 1'b1;
            cnt_val = skip_d;
          end
        end
      end
      wavrp_pkg::PH_SUBSKIP: begin
        if (phase_q == wavrp_pkg::PH_SUBSKIP && !in_data_i.file_start) begin
          skip_d = skip_d - 33'd1;
          if (skip_d == '0) do_list = 1'b1;
        end
      end
      default: ;
    endcase

    if (do_sub) begin
      skip_d = cnt_val;
      if (cnt_val == '0) do_list = 1'b1;
      else phase_d = wavrp_pkg::PH_SUBSKIP;
    end
    if (do_list) begin
      if (lrem_d == '0) begin
        do_top  = 1'b1;
        cnt_val = {32'd0, lpad_d};
      end else begin
        phase_d = wavrp_pkg::PH_SUBHDR;
      end
    end
    if (do_top) begin
      skip_d  = cnt_val;
      phase_d = (cnt_val == '0) ? wavrp_pkg::PH_HDR : wavrp_pkg::PH_SKIP;
    end

    if (in_data_i.file_end && !sent_d) begin
      r      = mk_summary(wavrp_pkg::KIND_INVALID, ch_d, rate_d, bits_d, dur_q,
                          len0_d, len1_d, len2_d);
      sent_d = 1'b1;
      phase_d = wavrp_pkg::PH_DONE;
      if (n_d == 2'd0) begin
        res0_d = r;
        n_d    = 2'd1;
      end else begin
        res1_d = r;
        n_d    = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wavrp_pkg::PH_RIFF; fbc_q <= '0; tag_q <= '0; len_q <= '0;
      lrem_q <= '0; sub_q <= '0; skip_q <= '0; ch_q <= '0; rate_q <= '0;
      bits_q <= '0; dur_q <= '0; seen_fmt_q <= 1'b0; sent_q <= 1'b0;
      tgt_q <= '0; pos_q <= '0; zero_q <= 1'b0; lpad_q <= 1'b0;
      len0_q <= '0; len1_q <= '0; len2_q <= '0; n_q <= '0; fcnt_q <= '0;
      res0_q <= '0; res1_q <= '0;
    end else if (cmd_i.step) begin
      phase_q <= phase_d; fbc_q <= fbc_d; tag_q <= tag_d; len_q <= len_d;
      lrem_q <= lrem_d; sub_q <= sub_d; skip_q <= skip_d; ch_q <= ch_d;
      rate_q <= rate_d; bits_q <= bits_d; seen_fmt_q <= seen_fmt_d; sent_q <= sent_d;
      tgt_q <= tgt_d; pos_q <= pos_d; zero_q <= zero_d; lpad_q <= lpad_d;
      len0_q <= len0_d; len1_q <= len1_d; len2_q <= len2_d; n_q <= n_d;
      fcnt_q <= fcnt_d; res0_q <= res0_d; res1_q <= res1_d;
      if (in_data_i.file_start) dur_q <= '0;
    end else if (cmd_i.div_step && cnt_q == 5'd31) begin
      dur_q               <= (dvs_q == '0) ? '0 : quo_next;
      res0_q.duration_sec <= (dvs_q == '0) ? '0 : quo_next;
    end
  end

  // Byte rate in two multiply steps, then a restoring divide, one bit a cycle.
  assign prod2     = 37'(prod1_q[31:0]) * 37'(bits_q[7:3]);
  assign rem_shift = {rem_q[31:0], quo_q[31]};
  assign quo_next  = {quo_q[30:0], rem_shift >= {1'b0, dvs_q}};

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      dvd_q <= len_d;
    end
    if (cmd_i.mul1) begin
      prod1_q <= 40'(rate_q) * 40'(ch_q);
    end
    if (cmd_i.mul2) begin
      dvs_q <= prod2[31:0];
      rem_q <= '0;
      quo_q <= dvd_q;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 5'd1;
      if (rem_shift >= {1'b0, dvs_q}) begin
        rem_q <= rem_shift - {1'b0, dvs_q};
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_shift;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.step_n   = n_d;
    sts_o.step_div = need_div;
    sts_o.n_q      = n_q;
    sts_o.div_last = (cnt_q == 5'd31);
    out_data_o     = cmd_i.out_sel ? res1_q : res0_q;
    out_data_o.last_of_run = cmd_i.out_sel | (n_q == 2'd1);
  end

endmodule

// File: design/wav_riff_header_parser_unit.sv
// ---------------------------------------------------------------------------
// WAV RIFF header parser
// Byte-serial RIFF/WAVE chunk walker with fmt capture, INFO text and summary.
// ---------------------------------------------------------------------------
// One file byte is taken per transfer and yields zero, one or two results,
// each delivered before the next byte is accepted. The byte that completes
// the data chunk header is first held for the byte-rate multiply, in the
// states CS_MUL1 and CS_MUL2, and then for the bit-serial divider in CS_DIV
// that produces the duration.
module wav_riff_header_parser_unit #(
  parameter int TEXT_CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wavrp_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wavrp_pkg::out_item_t out_data_o
);

  wavrp_pkg::cmd_t cmd;
  wavrp_pkg::sts_t sts;

  wavrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  wavrp_dp #(
    .TEXT_CAPACITY (TEXT_CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // A result is never shown in the same cycle a byte is taken.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("output valid while accepting input");

  // The summary of a data chunk waits for the divider.
  a_div_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts.step_div) |=> !out_valid_o && !in_ready_o)
    else $error("data summary not held for divide");

  a_kind_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.result_kind != 2'd3)) else $error("bad result kind");

endmodule
